FILE: design/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types and constants of the instruction executor: sizes of the
// register file, data memory and program, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

  localparam int unsigned DATA_WORDS    = 512;
  localparam int unsigned REG_COUNT     = 32;
  localparam int unsigned PROGRAM_DEPTH = 1024;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned REG_AW   = $clog2(REG_COUNT);
  localparam int unsigned IMM_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned DMEM_AW  = $clog2(DATA_WORDS);
  localparam int unsigned PC_W     = $clog2(PROGRAM_DEPTH);
  localparam int unsigned LEN_W    = $clog2(PROGRAM_DEPTH + 1);
  // Common width for the configured length and its clamped value.
  localparam int unsigned EFF_W    = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  // Signed width that holds pc + 1 + imm without overflow.
  localparam int unsigned TGT_W    = ((PC_W > IMM_W - 1) ? PC_W : IMM_W - 1) + 2;

  localparam logic [CFG_W-1:0] PROG_LEN_RESET = CFG_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_SUB     = 3'd1,
    OP_MUL     = 3'd2,
    OP_ADDI    = 3'd3,
    OP_LW      = 3'd4,
    OP_SW      = 3'd5,
    OP_BEQ     = 3'd6,
    OP_INVALID = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_BAD_ADDR   = 3'd2,
    ST_BAD_BRANCH = 3'd3,
    ST_BAD_OP     = 3'd4
  } status_e;

endpackage

`default_nettype wire

FILE: design/sce_instr_if.sv
// ----------------------------------------------------------------------------
// sce_instr_if
// Request channel carrying one decoded instruction, with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sce_instr_if;
  logic                                   valid;
  logic                                   ready;
  logic [sce_pkg::OP_W-1:0]               op;
  logic [sce_pkg::REG_AW-1:0]             src_reg;
  logic [sce_pkg::REG_AW-1:0]             tgt_reg;
  logic [sce_pkg::REG_AW-1:0]             dst_reg;
  logic signed [sce_pkg::IMM_W-1:0]       imm;

  modport source (output valid, op, src_reg, tgt_reg, dst_reg, imm, input ready);
  modport sink   (input valid, op, src_reg, tgt_reg, dst_reg, imm, output ready);
endinterface

`default_nettype wire

FILE: design/sce_result_if.sv
// ----------------------------------------------------------------------------
// sce_result_if
// Request channel carrying the outcome of one executed instruction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sce_result_if;
  logic                                   valid;
  logic                                   ready;
  logic [sce_pkg::STATUS_W-1:0]           status;
  logic                                   reg_written;
  logic [sce_pkg::REG_AW-1:0]             write_index;
  logic signed [sce_pkg::WORD_W-1:0]      write_value;
  logic                                   branch_taken;
  logic [sce_pkg::PC_W-1:0]               next_pc;

  modport source (output valid, status, reg_written, write_index, write_value,
                  branch_taken, next_pc, input ready);
  modport sink   (input valid, status, reg_written, write_index, write_value,
                  branch_taken, next_pc, output ready);
endinterface

`default_nettype wire

FILE: design/single_cycle_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// single_cycle_instruction_executor_core
// Executes decoded instructions against a 32-word register file and a
// data memory, reporting status, register or store value and next pc.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake      Carries
//   instr_i    in         valid/ready    op, src_reg, tgt_reg, dst_reg, imm
//   result_o   out        valid/ready    status, write fields, branch, pc
//   cfg_*      in         write enable   program_length
//
// One instruction is accepted every clock cycle unless the clearing pass
// runs or the execute stage is held by a stalled result. The register file
// is read at acceptance into the execute stage, the instruction executes
// there, and its outcome, with any load word, lands in the output register
// (the writeback stage), from which the result is offered. After reset the
// data memory is cleared one word a cycle, and no request is accepted until
// that is done. A stalled result holds the writeback stage; a request is
// still taken while the execute stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module single_cycle_instruction_executor_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sce_instr_if.sink                        instr_i,
  sce_result_if.source                     result_o,
  input  wire logic                        cfg_wr_en_i,
  input  wire logic [sce_pkg::CFG_W-1:0]   cfg_wr_data_i
);

  localparam int unsigned W   = sce_pkg::WORD_W;
  localparam int unsigned RAW = sce_pkg::REG_AW;
  localparam int unsigned DAW = sce_pkg::DMEM_AW;
  localparam int unsigned PCW = sce_pkg::PC_W;
  localparam int unsigned EW  = sce_pkg::EFF_W;
  localparam int unsigned TW  = sce_pkg::TGT_W;
  localparam int unsigned IW  = sce_pkg::IMM_W;

  // --------------------------------------------------------------------------
  // Storage. The register file has two read ports and one write port; both
  // arrays have registered read data. Register file entries that were never
  // written read as zero through their valid bits, which is also how
  // register 0 stays at zero: it is never written.
  // --------------------------------------------------------------------------
  logic [W-1:0]              rf_mem [sce_pkg::REG_COUNT];
  logic [sce_pkg::REG_COUNT-1:0] rf_vld_q;
  logic [W-1:0]              dm_mem [sce_pkg::DATA_WORDS];

  // Configuration and architectural pc.
  logic [sce_pkg::CFG_W-1:0] len_q;
  logic [PCW-1:0]            pc_q;

  // Clearing pass over the data memory.
  logic                      clr_busy_q;
  logic [DAW-1:0]            clr_addr_q;

  // Execute stage: instruction and register file read data.
  logic                      s1_vld_q;
  sce_pkg::op_e              s1_op_q;
  logic [RAW-1:0]            s1_rs_q, s1_rt_q, s1_rd_q;
  logic signed [IW-1:0]      s1_imm_q;
  logic [W-1:0]              ra_q, rb_q;
  logic                      ra_vld_q, rb_vld_q;

  // Write that landed in the register file at the edge that read the
  // operands of the instruction now in execute, which the read missed.
  logic                      byp_vld_q;
  logic [RAW-1:0]            byp_idx_q;
  logic [W-1:0]              byp_val_q;

  // Writeback stage, which is also the output register.
  logic                      s2_vld_q;
  sce_pkg::status_e          s2_status_q;
  logic                      s2_wr_q;
  logic                      s2_lw_q;
  logic [RAW-1:0]            s2_idx_q;
  logic [W-1:0]              s2_val_q;
  logic                      s2_taken_q;
  logic [PCW-1:0]            s2_npc_q;
  logic [W-1:0]              dm_rdata_q;

  // --------------------------------------------------------------------------
  // Flow control. The writeback stage frees when the result is taken; the
  // execute stage moves whenever the writeback stage is free after this edge.
  // --------------------------------------------------------------------------
  logic s2_retire, s1_move, in_accept;

  assign s2_retire     = s2_vld_q & result_o.ready;
  assign s1_move       = s1_vld_q & (~s2_vld_q | result_o.ready);
  assign instr_i.ready = ~clr_busy_q & (~s1_vld_q | s1_move);
  assign in_accept     = instr_i.valid & instr_i.ready;

  // Value that the writeback stage puts into the register file.
  logic [W-1:0] s2_wval;
  assign s2_wval = s2_lw_q ? dm_rdata_q : s2_val_q;

  // --------------------------------------------------------------------------
  // Execute stage. Operands are forwarded from the writeback stage first
  // (youngest), then from the write missed by the read, then the read data.
  // --------------------------------------------------------------------------
  logic [W-1:0]          op_a, op_b;
  logic [EW-1:0]         eff_len;
  logic [EW-1:0]         seq_pc;
  logic signed [TW-1:0]  br_tgt;
  logic signed [W:0]     mem_addr;
  logic [2*W-1:0]        product;
  logic [W-1:0]          result;
  logic                  wr_req;
  logic [RAW-1:0]        dest;
  logic                  taken;
  sce_pkg::status_e      status;
  logic [PCW-1:0]        npc;
  logic                  ok;
  logic                  do_store, do_load, do_wr;

  always_comb begin
    op_a = ra_vld_q ? ra_q : '0;
    if (byp_vld_q && byp_idx_q == s1_rs_q) begin
      op_a = byp_val_q;
    end
    if (s2_vld_q && s2_wr_q && s2_idx_q == s1_rs_q) begin
      op_a = s2_wval;
    end
    op_b = rb_vld_q ? rb_q : '0;
    if (byp_vld_q && byp_idx_q == s1_rt_q) begin
      op_b = byp_val_q;
    end
    if (s2_vld_q && s2_wr_q && s2_idx_q == s1_rt_q) begin
      op_b = s2_wval;
    end
  end

  // A length of zero counts as one, and any length beyond the program depth
  // is clamped to it.
  always_comb begin
    if (len_q == '0) begin
      eff_len = EW'(1);
    end else if (EW'(len_q) > EW'(sce_pkg::PROGRAM_DEPTH)) begin
      eff_len = EW'(sce_pkg::PROGRAM_DEPTH);
    end else begin
      eff_len = EW'(len_q);
    end
  end

  always_comb begin
    seq_pc = EW'(pc_q) + EW'(1);
    if (seq_pc >= eff_len) begin
      seq_pc = '0;
    end
  end

  assign br_tgt   = $signed({{(TW-PCW){1'b0}}, pc_q}) + TW'(1) + TW'(s1_imm_q);
  // The offset is only used when it is a multiple of four, so an
  // arithmetic shift gives the same word offset as a signed division.
  assign mem_addr = $signed({op_a[W-1], op_a}) + (W+1)'(s1_imm_q >>> 2);
  assign product  = op_a * op_b;

  always_comb begin
    result = '0;
    wr_req = 1'b0;
    dest   = s1_rd_q;
    taken  = 1'b0;
    status = sce_pkg::ST_OK;
    npc    = PCW'(seq_pc);
    case (s1_op_q)
      sce_pkg::OP_ADD: begin
        result = op_a + op_b;
        wr_req = 1'b1;
      end
      sce_pkg::OP_SUB: begin
        result = op_a - op_b;
        wr_req = 1'b1;
      end
      sce_pkg::OP_MUL: begin
        result = product[W-1:0];
        wr_req = 1'b1;
      end
      sce_pkg::OP_ADDI: begin
        result = op_a + W'(s1_imm_q);
        wr_req = 1'b1;
      end
      sce_pkg::OP_LW, sce_pkg::OP_SW: begin
        dest   = s1_rt_q;
        wr_req = (s1_op_q == sce_pkg::OP_LW);
        result = op_b;
        if (s1_imm_q[1:0] != 2'b00) begin
          status = sce_pkg::ST_MISALIGNED;
        end else if (mem_addr[W] ||
                     mem_addr >= $signed((W+1)'(sce_pkg::DATA_WORDS))) begin
          status = sce_pkg::ST_BAD_ADDR;
        end
      end
      sce_pkg::OP_BEQ: begin
        if (op_a == op_b) begin
          taken = 1'b1;
          if (br_tgt[TW-1] || br_tgt >= $signed(TW'(eff_len))) begin
            status = sce_pkg::ST_BAD_BRANCH;
          end else begin
            npc = PCW'(br_tgt);
          end
        end
      end
      default: begin
        status = sce_pkg::ST_BAD_OP;
      end
    endcase
    if (status != sce_pkg::ST_OK) begin
      npc = pc_q;
    end
  end

  assign ok       = (status == sce_pkg::ST_OK);
  assign do_store = s1_move & ok & (s1_op_q == sce_pkg::OP_SW);
  assign do_load  = s1_move & ok & (s1_op_q == sce_pkg::OP_LW);
  assign do_wr    = ok & wr_req & (dest != '0);

  // --------------------------------------------------------------------------
  // Data memory: one port, shared by the clearing pass, stores and loads.
  // A store writes as its instruction leaves execute, so a following load
  // reads the new word at its own edge.
  // --------------------------------------------------------------------------
  logic [DAW-1:0] dm_addr;
  assign dm_addr = clr_busy_q ? clr_addr_q : mem_addr[DAW-1:0];

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dm_mem[dm_addr] <= '0;
    end else if (do_store) begin
      dm_mem[dm_addr] <= op_b;
    end
    if (do_load) begin
      dm_rdata_q <= dm_mem[dm_addr];
    end
  end

  // Register file array: written as a result leaves, read as a request
  // enters, so the operands hold while the instruction waits in execute.
  always_ff @(posedge clk_i) begin
    if (s2_retire && s2_wr_q) begin
      rf_mem[s2_idx_q] <= s2_wval;
    end
    if (in_accept) begin
      ra_q <= rf_mem[instr_i.src_reg];
      rb_q <= rf_mem[instr_i.tgt_reg];
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers of the two stages.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= sce_pkg::op_e'(instr_i.op);
      s1_rs_q   <= instr_i.src_reg;
      s1_rt_q   <= instr_i.tgt_reg;
      s1_rd_q   <= instr_i.dst_reg;
      s1_imm_q  <= instr_i.imm;
      byp_idx_q <= s2_idx_q;
      byp_val_q <= s2_wval;
    end
    if (s1_move) begin
      s2_status_q <= status;
      s2_wr_q     <= do_wr;
      s2_lw_q     <= (s1_op_q == sce_pkg::OP_LW);
      s2_idx_q    <= do_wr ? dest : '0;
      s2_val_q    <= (ok && (do_wr || s1_op_q == sce_pkg::OP_SW)) ? result : '0;
      s2_taken_q  <= taken;
      s2_npc_q    <= npc;
    end
  end

  // --------------------------------------------------------------------------
  // Control state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q   <= '0;
      ra_vld_q   <= 1'b0;
      rb_vld_q   <= 1'b0;
      byp_vld_q  <= 1'b0;
      len_q      <= sce_pkg::PROG_LEN_RESET;
      pc_q       <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        len_q <= cfg_wr_data_i;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + DAW'(1);
        if (clr_addr_q == DAW'(sce_pkg::DATA_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (s2_retire && s2_wr_q) begin
        rf_vld_q[s2_idx_q] <= 1'b1;
      end
      if (in_accept) begin
        ra_vld_q  <= rf_vld_q[instr_i.src_reg];
        rb_vld_q  <= rf_vld_q[instr_i.tgt_reg];
        byp_vld_q <= s2_retire & s2_wr_q;
        s1_vld_q  <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q  <= 1'b0;
      end
      if (s1_move) begin
        pc_q     <= npc;
        s2_vld_q <= 1'b1;
      end else if (s2_retire) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result channel.
  // --------------------------------------------------------------------------
  assign result_o.valid        = s2_vld_q;
  assign result_o.status       = s2_status_q;
  assign result_o.reg_written  = s2_wr_q;
  assign result_o.write_index  = s2_idx_q;
  assign result_o.write_value  = $signed(s2_wr_q ? s2_wval : s2_val_q);
  assign result_o.branch_taken = s2_taken_q;
  assign result_o.next_pc      = s2_npc_q;

endmodule

`default_nettype wire

FILE: design/sce_checker.sv
// ----------------------------------------------------------------------------
// sce_checker
// Port-level checks on the result channel of the instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [sce_pkg::STATUS_W-1:0]      status_i,
  input wire logic                              reg_written_i,
  input wire logic [sce_pkg::REG_AW-1:0]        write_index_i,
  input wire logic [sce_pkg::WORD_W-1:0]        write_value_i,
  input wire logic                              branch_taken_i,
  input wire logic [sce_pkg::PC_W-1:0]          next_pc_i
);

  // A result that is not taken stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({status_i, reg_written_i, write_index_i, write_value_i,
               branch_taken_i, next_pc_i}))
    else $error("stalled result changed");

  // A failed instruction writes nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != sce_pkg::ST_OK |->
      !reg_written_i && write_index_i == '0 && write_value_i == '0)
    else $error("error result carries a write");

  // Register 0 is never reported as written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reg_written_i |-> write_index_i != '0)
    else $error("write to register zero reported");

  // Without a register write the index reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !reg_written_i |-> write_index_i == '0)
    else $error("index shown without a register write");

endmodule

bind single_cycle_instruction_executor_core sce_checker u_sce_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .status_i       (result_o.status),
  .reg_written_i  (result_o.reg_written),
  .write_index_i  (result_o.write_index),
  .write_value_i  (result_o.write_value),
  .branch_taken_i (result_o.branch_taken),
  .next_pc_i      (result_o.next_pc)
);

`default_nettype wire
